// ===== src/atc_pkg.sv =====
// shared types, constants and the acceptance table for the annealing coloring step
package atc_pkg;

  localparam int VERTEX_COUNT = 4096;
  localparam int VERTEX_BITS  = $clog2(VERTEX_COUNT);
  localparam int MAX_DEGREE   = 64;
  localparam int DEG_BITS     = $clog2(MAX_DEGREE);
  localparam int CNT_BITS     = DEG_BITS + 1;
  localparam int WEIGHT_BITS  = 16;
  localparam int SUM_BITS     = WEIGHT_BITS + DEG_BITS;
  localparam int ERR_BITS     = 34;
  localparam int TEMP_BITS    = 24;
  localparam int RND_BITS     = 16;
  localparam int EXP_ENTRIES  = 256;
  localparam int Q_BITS       = $clog2(EXP_ENTRIES);
  localparam int NUM_BITS     = SUM_BITS + 12;
  localparam int EDGE_ADDR_BITS = VERTEX_BITS + DEG_BITS;
  localparam logic [63:0] EXP_STEP_Q60 = 64'd1083069521826238951;

  // opcodes
  localparam logic [1:0] OP_FORCE   = 2'd0;
  localparam logic [1:0] OP_LINK    = 2'd1;
  localparam logic [1:0] OP_PROPOSE = 2'd2;

  // status codes
  localparam logic [1:0] ST_APPLIED  = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_BAD      = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] COLOR_INVALID = 2'd3;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [VERTEX_BITS-1:0] vertex;
    logic [VERTEX_BITS-1:0] other_vertex;
    logic [1:0]             new_color;
    logic [15:0]            weight;
    logic [TEMP_BITS-1:0]   temperature;
    logic [RND_BITS-1:0]    random_value;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [ERR_BITS-1:0] total_error;
    logic [6:0]          moved_degree;
  } rsp_t;

  // one row per vertex: color, degree and neighbor weight per color
  typedef struct packed {
    logic [1:0]                color;
    logic [CNT_BITS-1:0]       count;
    logic [2:0][SUM_BITS-1:0]  sum;
  } row_t;

  typedef struct packed {
    logic [VERTEX_BITS-1:0] peer;
    logic [WEIGHT_BITS-1:0] wt;
  } edge_t;

  // acceptance unit request and response
  typedef struct packed {
    logic                 start;
    logic [SUM_BITS-1:0]  delta;
    logic [TEMP_BITS-1:0] temp;
    logic [RND_BITS-1:0]  rnd;
  } acc_req_t;

  typedef struct packed {
    logic done;
    logic take;
  } acc_rsp_t;

  typedef logic [15:0] accept_table_t [EXP_ENTRIES];

  // exp(-q/16) table built at elaboration from Q0.60 products
  function automatic accept_table_t build_accept_table();
    accept_table_t t;
    logic [63:0]  v;
    logic [127:0] p;
    logic [63:0]  w;
    logic [63:0]  r;
    v = 64'd1 << 60;
    for (int q = 0; q < EXP_ENTRIES; q++) begin
      w = v >> 12;
      r = (64'd65535 * w + (64'd1 << 47)) >> 48;
      t[q] = r[15:0];
      p = {64'd0, v} * {64'd0, EXP_STEP_Q60};
      v = p[123:60];
    end
    return t;
  endfunction

  localparam accept_table_t ACCEPT_TABLE = build_accept_table();

  function automatic logic [SUM_BITS-1:0] get_sum(row_t r, logic [1:0] c);
    logic [SUM_BITS-1:0] s;
    case (c)
      2'd0:    s = r.sum[0];
      2'd1:    s = r.sum[1];
      2'd2:    s = r.sum[2];
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic row_t add_sum(row_t r, logic [1:0] c, logic [SUM_BITS-1:0] d);
    row_t o;
    o = r;
    case (c)
      2'd0:    o.sum[0] = r.sum[0] + d;
      2'd1:    o.sum[1] = r.sum[1] + d;
      2'd2:    o.sum[2] = r.sum[2] + d;
      default: o = r;
    endcase
    return o;
  endfunction

endpackage

// ===== src/atc_if.sv =====
// request and response channel interfaces
interface atc_req_if import atc_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface atc_rsp_if import atc_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/atc_ram.sv =====
// generic single write, single read ram with registered read
module atc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/atc_accept.sv =====
// metropolis acceptance unit: restoring division one quotient bit a cycle, then table compare
module atc_accept import atc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  acc_req_t req,
  output acc_rsp_t rsp
);
  logic                  busy;
  logic                  lookup;
  logic [3:0]            step;
  logic [NUM_BITS-1:0]   rem;
  logic [NUM_BITS-1:0]   dsh;
  logic [Q_BITS-1:0]     q;
  logic                  ge;

  assign ge = rem >= dsh;

  // one compare and subtract per cycle, first step tests q >= 256
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      lookup <= 1'b0;
      rsp    <= '0;
    end else begin
      if (req.start) begin
        busy     <= 1'b1;
        lookup   <= 1'b0;
        step     <= 4'd8;
        rem      <= {req.delta, 12'd0};
        dsh      <= NUM_BITS'({req.temp, 8'd0});
        q        <= '0;
        rsp.done <= 1'b0;
      end else if (lookup) begin
        lookup   <= 1'b0;
        busy     <= 1'b0;
        rsp.done <= 1'b1;
        rsp.take <= req.rnd < ACCEPT_TABLE[q];
      end else if (busy) begin
        dsh <= dsh >> 1;
        if (step == 4'd8) begin
          rsp.done <= ge;
          if (ge) begin
            busy     <= 1'b0;
            rsp.take <= 1'b0;
          end
        end else begin
          rsp.done <= 1'b0;
          if (ge) begin
            rem <= rem - dsh;
          end
          q <= {q[Q_BITS-2:0], ge};
          if (step == 4'd0) begin
            lookup <= 1'b1;
          end
        end
        step <= step - 4'd1;
      end else begin
        rsp.done <= 1'b0;
      end
    end
  end

  // only the start pulse launches work
  assert property (@(posedge clk) disable iff (rst) req.start |=> busy)
    else $error("acceptance unit did not start");
  assert property (@(posedge clk) disable iff (rst) rsp.done |-> !busy)
    else $error("acceptance unit done while busy");
endmodule

// ===== src/anneal_three_coloring_step.sv =====
// top level: sequencer, vertex row store, edge store and conflict total
// after reset a clearing pass writes all 4096 vertex rows, with ready low
// bad or no-op items go S_RD_V, S_DONE; add edge adds S_RD_U, S_LINK_V, S_LINK_U (full: S_RD_U to S_DONE)
// a proposal waits in S_DIV on the acceptance unit, one quotient bit a cycle
// a move walks the neighbor list through S_EDGE_RD, S_EDGE_WAIT and S_PEER_WR for each neighbor
// one item at a time; ready rises again in the same cycle that the result goes valid
module anneal_three_coloring_step import atc_pkg::*; (
  input logic         clk,
  input logic         rst,
  atc_req_if.sink     req,
  atc_rsp_if.source   rsp
);
  typedef enum logic [11:0] {
    S_CLEAR     = 12'b000000000001,
    S_IDLE      = 12'b000000000010,
    S_RD_V      = 12'b000000000100,
    S_RD_U      = 12'b000000001000,
    S_LINK_V    = 12'b000000010000,
    S_LINK_U    = 12'b000000100000,
    S_DIV       = 12'b000001000000,
    S_APPLY     = 12'b000010000000,
    S_EDGE_RD   = 12'b000100000000,
    S_EDGE_WAIT = 12'b001000000000,
    S_PEER_WR   = 12'b010000000000,
    S_DONE      = 12'b100000000000
  } state_t;

  state_t                  state;
  req_t                    item;
  row_t                    row_v;
  row_t                    row_u;
  edge_t                   cur_edge;
  logic [VERTEX_BITS-1:0]  clr_addr;
  logic [CNT_BITS-1:0]     idx;
  logic [ERR_BITS-1:0]     conflict;
  logic [1:0]              status;
  logic [6:0]              moved;
  logic                    out_valid;
  rsp_t                    out_data;

  logic                    row_we;
  logic [VERTEX_BITS-1:0]  row_waddr;
  row_t                    row_wdata;
  logic [VERTEX_BITS-1:0]  row_raddr;
  row_t                    row_rdata;
  logic                    edge_we;
  logic [EDGE_ADDR_BITS-1:0] edge_waddr;
  edge_t                   edge_wdata;
  logic [EDGE_ADDR_BITS-1:0] edge_raddr;
  edge_t                   edge_rdata;

  acc_req_t                acc_req;
  acc_rsp_t                acc_rsp;
  logic [SUM_BITS-1:0]     sum_to;
  logic [SUM_BITS-1:0]     sum_from;
  logic                    out_free;

  atc_ram #(.WIDTH($bits(row_t)), .DEPTH(VERTEX_COUNT)) u_rows (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  atc_ram #(.WIDTH($bits(edge_t)), .DEPTH(VERTEX_COUNT * MAX_DEGREE)) u_edges (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rdata)
  );

  atc_accept u_accept (.clk(clk), .rst(rst), .req(acc_req), .rsp(acc_rsp));

  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = out_valid;
  assign rsp.data   = out_data;
  assign out_free   = !out_valid || rsp.ready;
  assign sum_to     = get_sum(row_rdata, item.new_color);
  assign sum_from   = get_sum(row_rdata, row_rdata.color);

  // acceptance unit launch when a valid proposal to a new color does not lower the error and the temperature is nonzero
  always_comb begin
    acc_req.start = (state == S_RD_V) && (item.opcode == OP_PROPOSE) &&
                    (item.new_color != COLOR_INVALID) &&
                    (row_rdata.color != item.new_color) &&
                    (sum_to >= sum_from) && (item.temperature != '0);
    acc_req.delta = sum_to - sum_from;
    acc_req.temp  = item.temperature;
    acc_req.rnd   = item.random_value;
  end

  // memory port steering
  always_comb begin
    row_we     = 1'b0;
    row_waddr  = item.vertex;
    row_wdata  = row_v;
    edge_we    = 1'b0;
    edge_waddr = {item.vertex, row_v.count[DEG_BITS-1:0]};
    edge_wdata = '{peer: item.other_vertex, wt: item.weight};
    edge_raddr = {item.vertex, idx[DEG_BITS-1:0]};
    case (state)
      S_IDLE:      row_raddr = req.data.vertex;
      S_RD_V:      row_raddr = item.other_vertex;
      S_EDGE_WAIT: row_raddr = edge_rdata.peer;
      default:     row_raddr = item.vertex;
    endcase
    case (state)
      S_CLEAR: begin
        row_we    = 1'b1;
        row_waddr = clr_addr;
        row_wdata = '0;
      end
      S_LINK_V: begin
        row_we          = 1'b1;
        row_wdata       = add_sum(row_v, row_u.color, SUM_BITS'(item.weight));
        row_wdata.count = row_v.count + 1'b1;
        edge_we         = 1'b1;
      end
      S_LINK_U: begin
        row_we          = 1'b1;
        row_waddr       = item.other_vertex;
        row_wdata       = add_sum(row_u, row_v.color, SUM_BITS'(item.weight));
        row_wdata.count = row_u.count + 1'b1;
        edge_we         = 1'b1;
        edge_waddr      = {item.other_vertex, row_u.count[DEG_BITS-1:0]};
        edge_wdata      = '{peer: item.vertex, wt: item.weight};
      end
      S_APPLY: begin
        row_we          = 1'b1;
        row_wdata.color = item.new_color;
      end
      S_PEER_WR: begin
        row_we    = 1'b1;
        row_waddr = cur_edge.peer;
        row_wdata = add_sum(add_sum(row_rdata, row_v.color, -SUM_BITS'(cur_edge.wt)),
                            item.new_color, SUM_BITS'(cur_edge.wt));
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      conflict  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == VERTEX_BITS'(VERTEX_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            item  <= req.data;
            state <= S_RD_V;
          end
        end
        S_RD_V: begin
          row_v  <= row_rdata;
          moved  <= '0;
          status <= ST_BAD;
          state  <= S_DONE;
          case (item.opcode)
            OP_FORCE: begin
              if (item.new_color != COLOR_INVALID) begin
                status <= ST_APPLIED;
                if (row_rdata.color != item.new_color) begin
                  state <= S_APPLY;
                end
              end
            end
            OP_LINK: begin
              if (item.vertex != item.other_vertex) begin
                state <= S_RD_U;
              end
            end
            OP_PROPOSE: begin
              if (item.new_color != COLOR_INVALID && row_rdata.color != item.new_color) begin
                if (sum_to < sum_from) begin
                  status <= ST_APPLIED;
                  state  <= S_APPLY;
                end else if (acc_req.start) begin
                  state <= S_DIV;
                end else begin
                  status <= ST_REJECTED;
                end
              end
            end
            default: ;
          endcase
        end
        S_RD_U: begin
          row_u <= row_rdata;
          if (row_v.count >= CNT_BITS'(MAX_DEGREE) ||
              row_rdata.count >= CNT_BITS'(MAX_DEGREE)) begin
            status <= ST_FULL;
            state  <= S_DONE;
          end else begin
            state <= S_LINK_V;
          end
        end
        S_LINK_V: begin
          if (row_u.color == row_v.color) begin
            conflict <= conflict + ERR_BITS'(item.weight);
          end
          state <= S_LINK_U;
        end
        S_LINK_U: begin
          status <= ST_APPLIED;
          state  <= S_DONE;
        end
        S_DIV: begin
          if (acc_rsp.done) begin
            if (acc_rsp.take) begin
              status <= ST_APPLIED;
              state  <= S_APPLY;
            end else begin
              status <= ST_REJECTED;
              state  <= S_DONE;
            end
          end
        end
        S_APPLY: begin
          conflict <= conflict + ERR_BITS'(get_sum(row_v, item.new_color))
                               - ERR_BITS'(get_sum(row_v, row_v.color));
          moved    <= 7'(row_v.count);
          idx      <= '0;
          state    <= (row_v.count == '0) ? S_DONE : S_EDGE_RD;
        end
        S_EDGE_RD: begin
          state <= S_EDGE_WAIT;
        end
        S_EDGE_WAIT: begin
          cur_edge <= edge_rdata;
          state    <= S_PEER_WR;
        end
        S_PEER_WR: begin
          idx   <= idx + 1'b1;
          state <= (idx + 1'b1 == row_v.count) ? S_DONE : S_EDGE_RD;
        end
        S_DONE: begin
          if (out_free) begin
            out_data  <= '{status: status, total_error: conflict, moved_degree: moved};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an accepted item blocks the input until its result is queued
  assert property (@(posedge clk) disable iff (rst) (req.valid && req.ready) |=> !req.ready)
    else $error("input accepted twice in a row");
  // only a taken move reports a degree
  assert property (@(posedge clk) disable iff (rst)
                   rsp.valid |-> (rsp.data.moved_degree == '0 || rsp.data.status == ST_APPLIED))
    else $error("degree reported for an unmoved vertex");
  // the acceptance unit answers only while it is awaited
  assert property (@(posedge clk) disable iff (rst) acc_rsp.done |-> state == S_DIV)
    else $error("stray acceptance result");
  // the neighbor walk stays below the degree
  assert property (@(posedge clk) disable iff (rst) state == S_EDGE_RD |-> idx < row_v.count)
    else $error("neighbor walk past the degree");
endmodule

// ===== test/anneal_three_coloring_step_test.sv =====
// self-checking testbench for the annealing three-coloring step
`timescale 1ns / 1ps

module anneal_three_coloring_step_test;
  import atc_pkg::*;

  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam int RANDOM_ITEMS = 1100;
  localparam int POOL_SIZE = 12;
  localparam int HOLD_CYCLES = 2000;

  // coloring state mirror, expected results and mismatch count
  class coloring_scoreboard;
    logic [1:0]          color [VERTEX_COUNT];
    logic [SUM_BITS-1:0] wsum [VERTEX_COUNT][3];
    int                  degree [VERTEX_COUNT];
    logic [VERTEX_BITS-1:0] peer [VERTEX_COUNT][MAX_DEGREE];
    logic [WEIGHT_BITS-1:0] peer_wt [VERTEX_COUNT][MAX_DEGREE];
    logic [ERR_BITS-1:0] conflict;
    logic [15:0]         exp_table [EXP_ENTRIES];
    rsp_t                pending [$];
    int                  errors;

    function new();
      logic [63:0]  v;
      logic [127:0] p;
      logic [63:0]  r;
      for (int i = 0; i < VERTEX_COUNT; i++) begin
        color[i] = '0;
        degree[i] = 0;
        for (int c = 0; c < 3; c++) wsum[i][c] = '0;
      end
      conflict = '0;
      errors = 0;
      // exp(-q/16) in Q0.60, rounded to 16 bits half up
      v = 64'd1 << 60;
      for (int q = 0; q < EXP_ENTRIES; q++) begin
        r = (64'd65535 * (v >> 12) + (64'd1 << 47)) >> 48;
        exp_table[q] = r[15:0];
        p = {64'd0, v} * {64'd0, EXP_STEP_Q60};
        v = p[123:60];
      end
    endfunction

    function void move_vertex(int v, logic [1:0] c);
      logic [1:0] old;
      old = color[v];
      conflict = conflict + ERR_BITS'(wsum[v][c]) - ERR_BITS'(wsum[v][old]);
      for (int i = 0; i < degree[v]; i++) begin
        wsum[peer[v][i]][old] -= SUM_BITS'(peer_wt[v][i]);
        wsum[peer[v][i]][c] += SUM_BITS'(peer_wt[v][i]);
      end
      color[v] = c;
    endfunction

    // predict the result of an accepted item and queue it
    function void note(req_t r);
      rsp_t e;
      int v, u;
      longint unsigned gto, gfrom, q;
      bit take;
      v = r.vertex;
      u = r.other_vertex;
      e.status = ST_BAD;
      e.moved_degree = '0;
      case (r.opcode)
        OP_FORCE: begin
          if (r.new_color != COLOR_INVALID) begin
            e.status = ST_APPLIED;
            if (color[v] != r.new_color) begin
              move_vertex(v, r.new_color);
              e.moved_degree = 7'(degree[v]);
            end
          end
        end
        OP_LINK: begin
          if (v != u) begin
            if (degree[v] >= MAX_DEGREE || degree[u] >= MAX_DEGREE) begin
              e.status = ST_FULL;
            end else begin
              peer[v][degree[v]] = r.other_vertex;
              peer_wt[v][degree[v]] = r.weight;
              degree[v]++;
              peer[u][degree[u]] = r.vertex;
              peer_wt[u][degree[u]] = r.weight;
              degree[u]++;
              wsum[v][color[u]] += SUM_BITS'(r.weight);
              wsum[u][color[v]] += SUM_BITS'(r.weight);
              if (color[u] == color[v]) conflict += ERR_BITS'(r.weight);
              e.status = ST_APPLIED;
            end
          end
        end
        OP_PROPOSE: begin
          if (r.new_color != COLOR_INVALID && color[v] != r.new_color) begin
            gto = wsum[v][r.new_color];
            gfrom = wsum[v][color[v]];
            take = 0;
            if (gto < gfrom) begin
              take = 1;
            end else if (r.temperature != 0) begin
              q = ((gto - gfrom) * 4096) / r.temperature;
              if (q < EXP_ENTRIES && r.random_value < exp_table[q]) take = 1;
            end
            if (take) begin
              move_vertex(v, r.new_color);
              e.moved_degree = 7'(degree[v]);
              e.status = ST_APPLIED;
            end else begin
              e.status = ST_REJECTED;
            end
          end
        end
        default: e.status = ST_BAD;
      endcase
      e.total_error = conflict;
      pending.push_back(e);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        report("unexpected result, status", got.status, 0);
      end else begin
        e = pending.pop_front();
        if (got.status !== e.status) report("status", got.status, e.status);
        if (got.total_error !== e.total_error)
          report("total_error", got.total_error, e.total_error);
        if (got.moved_degree !== e.moved_degree)
          report("moved_degree", got.moved_degree, e.moved_degree);
      end
    endtask
  endclass

  logic clk;
  logic rst;
  atc_req_if req ();
  atc_rsp_if rsp ();

  coloring_scoreboard sb;
  bit calm;
  int results_seen;
  logic [VERTEX_BITS-1:0] pool [POOL_SIZE];

  anneal_three_coloring_step i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // offer one item, with random idle cycles first, until accepted
  task send_item(req_t r);
    if (!calm && $urandom_range(99) < 34) begin
      req.valid <= 1'b0;
      while ($urandom_range(99) < 34) @(posedge clk);
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data <= r;
    do @(posedge clk); while (!req.ready);
    sb.note(r);
  endtask

  task send_fields(logic [1:0] op, int v, int u, logic [1:0] c, int w, int t, int rv);
    req_t r;
    r.opcode = op;
    r.vertex = VERTEX_BITS'(v);
    r.other_vertex = VERTEX_BITS'(u);
    r.new_color = c;
    r.weight = 16'(w);
    r.temperature = TEMP_BITS'(t);
    r.random_value = RND_BITS'(rv);
    send_item(r);
  endtask

  function logic [TEMP_BITS-1:0] pick_temperature();
    int k;
    k = $urandom_range(9);
    if (k < 2) return '0;
    if (k < 5) return TEMP_BITS'($urandom);
    if (k < 7) return TEMP_BITS'($urandom_range(1, 4096));
    return TEMP_BITS'($urandom_range(24'h100000, 24'hFFFFFF));
  endfunction

  // mostly well-formed edits on a small vertex pool, some noise
  function req_t random_item();
    req_t r;
    int k;
    r.opcode = 2'($urandom);
    r.weight = 16'($urandom);
    r.random_value = RND_BITS'($urandom);
    r.vertex = pool[$urandom_range(POOL_SIZE - 1)];
    r.other_vertex = pool[$urandom_range(POOL_SIZE - 1)];
    r.new_color = 2'($urandom_range(2));
    r.temperature = pick_temperature();
    k = $urandom_range(99);
    if (k < 45) begin
      r.opcode = OP_LINK;
      if ($urandom_range(3) == 0) r.weight = 16'($urandom_range(255));
    end else if (k < 70) begin
      r.opcode = OP_PROPOSE;
    end else if (k < 85) begin
      r.opcode = OP_FORCE;
    end else if (k < 92) begin
      r.other_vertex = VERTEX_BITS'($urandom);
      if (r.opcode == OP_PROPOSE && $urandom_range(1)) r.new_color = COLOR_INVALID;
    end else begin
      r.opcode = 2'($urandom_range(3));
      r.new_color = 2'($urandom_range(3));
    end
    return r;
  endfunction

  // response side: random stalls, one long hold-off
  initial begin
    int hold_left;
    bit held;
    rsp.ready = 1'b0;
    hold_left = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        sb.check(rsp.data);
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (!held && results_seen == 200) begin
        held = 1;
        hold_left = HOLD_CYCLES;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  // stimulus and end of run
  initial begin
    sb = new();
    calm = 0;
    results_seen = 0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.data = '0;
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) pool[i] = VERTEX_BITS'($urandom);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    send_fields(OP_FORCE, 10, 0, 2'd2, 0, 0, 0);
    send_fields(OP_FORCE, 10, 0, 2'd2, 0, 0, 0);
    send_fields(OP_FORCE, 10, 0, COLOR_INVALID, 0, 0, 0);
    send_fields(OP_UNDEFINED, 10, 11, 2'd1, 5, 5, 5);
    send_fields(OP_LINK, 10, 10, 2'd0, 7, 0, 0);
    send_fields(OP_LINK, 10, 11, 2'd0, 65535, 0, 0);
    send_fields(OP_LINK, 11, 12, 2'd0, 0, 0, 0);
    send_fields(OP_LINK, 0, 4095, 2'd0, 1, 0, 0);
    send_fields(OP_LINK, 11, 4095, 2'd0, 300, 0, 0);
    send_fields(OP_PROPOSE, 10, 0, 2'd2, 0, 100, 0);
    send_fields(OP_PROPOSE, 10, 0, COLOR_INVALID, 0, 100, 0);
    send_fields(OP_PROPOSE, 4095, 0, 2'd1, 0, 0, 0);
    send_fields(OP_PROPOSE, 12, 0, 2'd1, 0, 0, 0);
    send_fields(OP_PROPOSE, 12, 0, 2'd1, 0, 100, 65535);
    send_fields(OP_PROPOSE, 12, 0, 2'd1, 0, 100, 0);
    send_fields(OP_PROPOSE, 11, 0, 2'd2, 0, 1, 0);
    send_fields(OP_PROPOSE, 11, 0, 2'd2, 0, 24'hFFFFFF, 0);
    send_fields(OP_FORCE, 4095, 0, 2'd0, 0, 0, 0);

    // random items, with a stretch of no idling
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 300 && n < 500);
      send_item(random_item());
    end
    @(posedge clk);
    req.valid <= 1'b0;
    calm = 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/atc_pkg.sv
src/atc_if.sv
src/atc_ram.sv
src/atc_accept.sv
src/anneal_three_coloring_step.sv
test/anneal_three_coloring_step_test.sv
